// ----- hdl/apgrm_pkg.sv -----
// Shared types, constants and the quarter-wave cosine and sine tables of the ambisonic panner.
// Depends on nothing; imported by the top level of the panner.
package apgrm_pkg;

    localparam int MAX_SPEAKERS    = 8;
    localparam int COS_TABLE_DEPTH = 1024;
    localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH);
    localparam int QTAB_W          = COS_IDX_W - 2;
    localparam int QTAB_DEPTH      = COS_TABLE_DEPTH / 4;
    localparam int TAB_W           = 25;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    localparam logic [3:0]  RST_NUM_SPEAKERS = 4'd8;
    localparam logic [3:0]  RST_PAN_ORDER    = 4'd3;
    localparam logic [24:0] RST_RAMP_RECIP   = 25'd262144;
    localparam logic [63:0] RST_SPK_AZIM_LO  = 64'h6000_4000_2000_0000;
    localparam logic [63:0] RST_SPK_AZIM_HI  = 64'hE000_C000_A000_8000;
    localparam logic [63:0] RST_SPK_GAIN_LO  = 64'h1000_1000_1000_1000;
    localparam logic [63:0] RST_SPK_GAIN_HI  = 64'h1000_1000_1000_1000;
    localparam logic [24:0] RAMP_MAX         = 25'd16777216;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_SPEAKERS = 3'd0,
        CFG_PAN_ORDER    = 3'd1,
        CFG_RAMP_RECIP   = 3'd2,
        CFG_SPK_AZIM_LO  = 3'd3,
        CFG_SPK_AZIM_HI  = 3'd4,
        CFG_SPK_GAIN_LO  = 3'd5,
        CFG_SPK_GAIN_HI  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic               req_type;
        logic [15:0]        src_azimuth;
        logic signed [23:0] sample_in;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]         speaker_index;
        logic signed [23:0] speaker_sample;
        logic               last_of_run;
    } t_out_beat;

    typedef logic [QTAB_DEPTH-1:0][TAB_W-1:0] t_qtab;

    // Builds one quarter turn of cosine or sine magnitudes in Q24 from a Taylor
    // series on Q30 values. Evaluated only at elaboration.
    function automatic t_qtab build_qtab(input logic want_sin);
        t_qtab           tab;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          acc;
        int              j;
        tab = '0;
        for (j = 0; j < QTAB_DEPTH; j++) begin
            r  = 64'(j) << (32 - COS_IDX_W);
            x  = (r * Q30_HALF_PI) >> 30;
            x2 = (x * x) >> 30;
            if (!want_sin) begin
                t   = Q30_ONE;
                acc = longint'(t);
                t   = ((t * x2) >> 30) / 2;   acc = acc - longint'(t);
                t   = ((t * x2) >> 30) / 12;  acc = acc + longint'(t);
                t   = ((t * x2) >> 30) / 30;  acc = acc - longint'(t);
                t   = ((t * x2) >> 30) / 56;  acc = acc + longint'(t);
                t   = ((t * x2) >> 30) / 90;  acc = acc - longint'(t);
                t   = ((t * x2) >> 30) / 132; acc = acc + longint'(t);
                t   = ((t * x2) >> 30) / 182; acc = acc - longint'(t);
            end else begin
                t   = x;
                acc = longint'(t);
                t   = ((t * x2) >> 30) / 6;   acc = acc - longint'(t);
                t   = ((t * x2) >> 30) / 20;  acc = acc + longint'(t);
                t   = ((t * x2) >> 30) / 42;  acc = acc - longint'(t);
                t   = ((t * x2) >> 30) / 72;  acc = acc + longint'(t);
                t   = ((t * x2) >> 30) / 110; acc = acc - longint'(t);
                t   = ((t * x2) >> 30) / 156; acc = acc + longint'(t);
            end
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > longint'(Q30_ONE)) begin
                acc = longint'(Q30_ONE);
            end
            tab[j] = TAB_W'((acc + 32) >>> 6);
        end
        return tab;
    endfunction

    localparam t_qtab COS_QTAB = build_qtab(1'b0);
    localparam t_qtab SIN_QTAB = build_qtab(1'b1);

endpackage

// ----- hdl/ambisonic_pan_gain_ramp_mixer.sv -----
// Top level of the 2D ambisonic panner with ramped speaker weights.
// Depends on apgrm_pkg for beat types, register indexes and the cosine and sine tables.

// The block pans one mono source onto up to eight loudspeakers. A direction beat
// (req_type 0) carries the source azimuth in 16-bit turns; for every speaker in use
// the block sums one half and pan_order harmonic cosines of the source-to-speaker
// angle, scales the result by 2/N and the speaker gain to get a Q8.24 target weight,
// and sets that speaker's per-sample increment to (target - weight) * ramp_recip. It
// produces no output beats. A sample beat (req_type 1) emits N output beats, one
// per speaker in index order; each speaker's weight is first ramped by its increment
// and the beat is that weight times the sample saturated to 24 bits, with
// last_of_run set on the final one. Everything runs on one small sequencer around a
// single shared signed multiplier; the division by the speaker count is a bit-serial
// restoring divider. A sample beat occupies the block through a ramp add, multiply
// and output load per speaker, plus any time the output is stalled. A direction beat
// occupies it, per speaker, through a registered table read and accumulate per
// harmonic, the serial divider, and the gain and ramp multiplies. Input ready is
// high only while the sequencer is idle, but the last output beat sits in its own
// register, so the next input beat is taken while that beat still waits.
// Configuration registers are written through a plain write port and must only
// change while the block is idle with no output pending. Weights and increments
// reset to zero at once; no clearing pass is needed.
module ambisonic_pan_gain_ramp_mixer
    import apgrm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data
);

    localparam int SUM_W   = 30;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SHR_W   = PROD_W - 24;
    localparam int DVD_W   = 34;
    localparam int DCNT_W  = $clog2(DVD_W);
    localparam logic signed [SUM_W-1:0] SUM_BIAS = SUM_W'(8388608);

    typedef enum logic [13:0] {
        S_IDLE     = 14'h0001,
        S_DIR_INIT = 14'h0002,
        S_DIR_RD   = 14'h0004,
        S_DIR_ACC  = 14'h0008,
        S_DIR_GAIN = 14'h0010,
        S_DIR_PREP = 14'h0020,
        S_DIR_DIV  = 14'h0040,
        S_DIR_TGT  = 14'h0080,
        S_DIR_DIFF = 14'h0100,
        S_DIR_MUL  = 14'h0200,
        S_DIR_SAVE = 14'h0400,
        S_SMP_ADD  = 14'h0800,
        S_SMP_MUL  = 14'h1000,
        S_SMP_OUT  = 14'h2000
    } t_state;

    // Truncating division by 2^24: bias negative values before the arithmetic shift.
    function automatic logic signed [SHR_W-1:0] shr24_trunc(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] biased;
        biased = p + (p[PROD_W-1] ? PROD_W'(24'hFF_FFFF) : PROD_W'(0));
        return biased[PROD_W-1:24];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SHR_W-1:0] v);
        logic signed [31:0] res;
        if (v > SHR_W'(32'sh7FFF_FFFF)) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -(SHR_W'(33'sh0_8000_0000))) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [SHR_W-1:0] v);
        logic signed [23:0] res;
        if (v > SHR_W'(24'sh7F_FFFF)) begin
            res = 24'sh7F_FFFF;
        end else if (v < -(SHR_W'(25'sh080_0000))) begin
            res = 24'sh80_0000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    // Quadrant fold of the stored quarter-wave tables.
    function automatic logic signed [TAB_W:0] cos_value(input logic [15:0] ang);
        logic [COS_IDX_W-1:0] idx;
        logic [1:0]           quad;
        logic [QTAB_W-1:0]    j;
        logic signed [TAB_W:0] mag;
        idx  = ang[15 -: COS_IDX_W];
        quad = idx[COS_IDX_W-1 -: 2];
        j    = idx[QTAB_W-1:0];
        mag  = quad[0] ? $signed({1'b0, SIN_QTAB[j]}) : $signed({1'b0, COS_QTAB[j]});
        return (quad[1] ^ quad[0]) ? -mag : mag;
    endfunction

    // Configuration registers.
    logic [3:0]  r_num_speakers;
    logic [3:0]  r_pan_order;
    logic [24:0] r_ramp_recip;
    logic [63:0] r_azim_lo;
    logic [63:0] r_azim_hi;
    logic [63:0] r_gain_lo;
    logic [63:0] r_gain_hi;

    // Sequencer state.
    t_state              r_state, n_state;
    logic [2:0]          r_k, n_k;
    logic [3:0]          r_l, n_l;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    logic                r_out_vld, n_out_vld;

    // Per-speaker state: Q8.24 weights and their per-sample increments.
    logic signed [31:0]  r_cur  [MAX_SPEAKERS];
    logic signed [31:0]  r_step [MAX_SPEAKERS];

    // Datapath registers.
    logic [15:0]              r_src;
    logic signed [23:0]       r_smp;
    logic [15:0]              r_rel;
    logic [15:0]              r_ang;
    logic signed [TAB_W:0]    r_tab;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_neg;
    logic [DVD_W-1:0]         r_dvd;
    logic [2:0]               r_rem;
    logic signed [31:0]       r_target;
    logic signed [32:0]       r_diff;
    t_out_beat                r_out;

    // Combinational helpers.
    logic                      in_acc;
    logic                      out_load;
    logic [3:0]                n_eff;
    logic [2:0]                n_last;
    logic                      k_is_last;
    logic [63:0]               azim_word;
    logic [63:0]               gain_word;
    logic [15:0]               spk_azim;
    logic [15:0]               spk_gain;
    logic [24:0]               scale;
    logic signed [31:0]        cur_k;
    logic signed [31:0]        step_k;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [PROD_W-1:0]         abs_p;
    logic [3:0]                rem_sh;
    logic                      div_ge;
    logic [3:0]                rem_nx;
    logic                      tgt_pos_ovf;
    logic                      tgt_neg_ovf;
    logic signed [31:0]        tgt_val;
    logic signed [32:0]        ramp_sum;
    logic signed [31:0]        ramp_val;
    logic signed [31:0]        step_val;
    logic signed [23:0]        out_val;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_SMP_OUT) && (!r_out_vld || i_out_ready);

    // Speaker count outside 1..MAX acts as the nearest bound.
    always_comb begin
        if (r_num_speakers == 4'd0) begin
            n_eff = 4'd1;
        end else if (r_num_speakers > 4'(MAX_SPEAKERS)) begin
            n_eff = 4'(MAX_SPEAKERS);
        end else begin
            n_eff = r_num_speakers;
        end
    end

    assign n_last    = 3'(n_eff - 4'd1);
    assign k_is_last = (r_k == n_last);

    assign azim_word = r_k[2] ? r_azim_hi : r_azim_lo;
    assign gain_word = r_k[2] ? r_gain_hi : r_gain_lo;
    assign spk_azim  = azim_word[{r_k[1:0], 4'b0000} +: 16];
    assign spk_gain  = gain_word[{r_k[1:0], 4'b0000} +: 16];
    assign scale     = (r_ramp_recip > RAMP_MAX) ? RAMP_MAX : r_ramp_recip;
    assign cur_k     = r_cur[r_k];
    assign step_k    = r_step[r_k];

    // The shared multiplier: gain scaling, ramp increment and output sample.
    always_comb begin
        case (r_state)
            S_DIR_GAIN: begin
                mul_a = {{(MUL_A_W-SUM_W){r_sum[SUM_W-1]}}, r_sum};
                mul_b = {{(MUL_B_W-17){1'b0}}, spk_gain, 1'b0};
            end
            S_DIR_MUL: begin
                mul_a = {{(MUL_A_W-33){r_diff[32]}}, r_diff};
                mul_b = {{(MUL_B_W-25){1'b0}}, scale};
            end
            default: begin
                mul_a = {{(MUL_A_W-32){cur_k[31]}}, cur_k};
                mul_b = {{(MUL_B_W-24){r_smp[23]}}, r_smp};
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign abs_p = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);

    // One restoring step of the divide by the speaker count.
    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign div_ge = (rem_sh >= n_eff);
    assign rem_nx = div_ge ? (rem_sh - n_eff) : rem_sh;

    // Sign and saturate the quotient to the 32-bit target weight.
    assign tgt_pos_ovf = |r_dvd[DVD_W-1:31];
    assign tgt_neg_ovf = (|r_dvd[DVD_W-1:32]) || (r_dvd[31] && (|r_dvd[30:0]));
    always_comb begin
        if (r_neg) begin
            tgt_val = tgt_neg_ovf ? 32'sh8000_0000 : -$signed(r_dvd[31:0]);
        end else begin
            tgt_val = tgt_pos_ovf ? 32'sh7FFF_FFFF : $signed(r_dvd[31:0]);
        end
    end

    assign ramp_sum = {cur_k[31], cur_k} + {step_k[31], step_k};
    assign ramp_val = sat32({{(SHR_W-33){ramp_sum[32]}}, ramp_sum});
    assign step_val = sat32(shr24_trunc(r_prod));
    assign out_val  = sat24(shr24_trunc(r_prod));

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_l       = r_l;
        n_dcnt    = r_dcnt;
        n_out_vld = out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_vld);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_k     = 3'd0;
                    n_state = i_in_data.req_type ? S_SMP_ADD : S_DIR_INIT;
                end
            end
            S_DIR_INIT: begin
                n_l     = 4'd1;
                n_state = (r_pan_order == 4'd0) ? S_DIR_GAIN : S_DIR_RD;
            end
            S_DIR_RD: begin
                n_state = S_DIR_ACC;
            end
            S_DIR_ACC: begin
                if (r_l == r_pan_order) begin
                    n_state = S_DIR_GAIN;
                end else begin
                    n_l     = r_l + 4'd1;
                    n_state = S_DIR_RD;
                end
            end
            S_DIR_GAIN: begin
                n_state = S_DIR_PREP;
            end
            S_DIR_PREP: begin
                n_dcnt  = '0;
                n_state = S_DIR_DIV;
            end
            S_DIR_DIV: begin
                if (r_dcnt == DCNT_W'(DVD_W - 1)) begin
                    n_state = S_DIR_TGT;
                end else begin
                    n_dcnt = r_dcnt + DCNT_W'(1);
                end
            end
            S_DIR_TGT: begin
                n_state = S_DIR_DIFF;
            end
            S_DIR_DIFF: begin
                n_state = S_DIR_MUL;
            end
            S_DIR_MUL: begin
                n_state = S_DIR_SAVE;
            end
            S_DIR_SAVE: begin
                if (k_is_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = S_DIR_INIT;
                end
            end
            S_SMP_ADD: begin
                n_state = S_SMP_MUL;
            end
            S_SMP_MUL: begin
                n_state = S_SMP_OUT;
            end
            S_SMP_OUT: begin
                if (out_load) begin
                    if (k_is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 3'd1;
                        n_state = S_SMP_ADD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and per-speaker weights.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_k            <= 3'd0;
            r_l            <= 4'd0;
            r_dcnt         <= '0;
            r_out_vld      <= 1'b0;
            r_num_speakers <= RST_NUM_SPEAKERS;
            r_pan_order    <= RST_PAN_ORDER;
            r_ramp_recip   <= RST_RAMP_RECIP;
            r_azim_lo      <= RST_SPK_AZIM_LO;
            r_azim_hi      <= RST_SPK_AZIM_HI;
            r_gain_lo      <= RST_SPK_GAIN_LO;
            r_gain_hi      <= RST_SPK_GAIN_HI;
            for (int i = 0; i < MAX_SPEAKERS; i++) begin
                r_cur[i]  <= '0;
                r_step[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_l       <= n_l;
            r_dcnt    <= n_dcnt;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_NUM_SPEAKERS: r_num_speakers <= i_cfg_data[3:0];
                    CFG_PAN_ORDER:    r_pan_order    <= i_cfg_data[3:0];
                    CFG_RAMP_RECIP:   r_ramp_recip   <= i_cfg_data[24:0];
                    CFG_SPK_AZIM_LO:  r_azim_lo      <= i_cfg_data;
                    CFG_SPK_AZIM_HI:  r_azim_hi      <= i_cfg_data;
                    CFG_SPK_GAIN_LO:  r_gain_lo      <= i_cfg_data;
                    CFG_SPK_GAIN_HI:  r_gain_hi      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == S_DIR_SAVE) begin
                r_step[r_k] <= step_val;
            end
            if (r_state == S_SMP_ADD) begin
                r_cur[r_k] <= ramp_val;
            end
        end
    end

    // Datapath registers; they carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_src <= i_in_data.src_azimuth;
            r_smp <= i_in_data.sample_in;
        end
        case (r_state)
            S_DIR_INIT: begin
                r_rel <= r_src - spk_azim;
                r_ang <= r_src - spk_azim;
                r_sum <= SUM_BIAS;
            end
            S_DIR_RD: begin
                r_tab <= cos_value(r_ang);
            end
            S_DIR_ACC: begin
                r_sum <= r_sum + {{(SUM_W-TAB_W-1){r_tab[TAB_W]}}, r_tab};
                r_ang <= r_ang + r_rel;
            end
            S_DIR_GAIN, S_DIR_MUL, S_SMP_MUL: begin
                r_prod <= mul_p;
            end
            S_DIR_PREP: begin
                r_neg <= r_prod[PROD_W-1];
                r_dvd <= abs_p[DVD_W+11:12];
                r_rem <= 3'd0;
            end
            S_DIR_DIV: begin
                r_dvd <= {r_dvd[DVD_W-2:0], div_ge};
                r_rem <= rem_nx[2:0];
            end
            S_DIR_TGT: begin
                r_target <= tgt_val;
            end
            S_DIR_DIFF: begin
                r_diff <= {r_target[31], r_target} - {cur_k[31], cur_k};
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out.speaker_index  <= r_k;
            r_out.speaker_sample <= out_val;
            r_out.last_of_run    <= k_is_last;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // Accepting an input beat always takes the sequencer out of idle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input ready stayed high after an accepted beat");

    // A new output beat only appears from the output load step of a sample.
    a_load_from_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_SMP_OUT))
        else $error("output beat appeared outside the sample output step");

    // While a beat that is not the last of its run waits, the run is still in progress.
    a_run_in_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last_of_run) |-> !o_in_ready)
        else $error("block idle while a run is only partly delivered");
`endif

endmodule
